>>> rtl/rle_pkg.sv
// Shared types for the literal/run packet encoder: states, emit selects, command and status.
package rle_pkg;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FIN,
        ST_SEND_CNT,
        ST_SEND_LIT,
        ST_SEND_RC,
        ST_SEND_RV
    } t_state;

    // Source of the byte loaded into the output register.
    typedef enum logic [1:0] {
        SEL_CNT,
        SEL_LIT,
        SEL_RC,
        SEL_RV
    } t_emit_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic      cap_in;
        logic      run_ext;
        logic      run_new;
        logic      run_clr;
        logic      append;
        logic      pkt_run;
        logic      pkt_zero;
        logic      lit_adv;
        logic      fill_clr;
        logic      emit;
        t_emit_sel emit_sel;
        logic      emit_last;
        logic      emit_done;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic extend;
        logic run_none;
        logic run_multi;
        logic buf_full;
        logic fill_zero;
        logic lit_end;
        logic fin;
        logic out_free;
    } t_dp_status;

endpackage

>>> rtl/rle_literal_run_encoder.sv
// Top level of the literal/run packet encoder: controller plus datapath.
//
// Raw bytes arrive on the slave stream, one per transfer; tlast marks the
// last byte of a stream. Encoded bytes leave on the master stream as packets:
// literal count, that many literal bytes, run count, run value. tuser flags
// the last encoded byte caused by one input byte; tlast flags the final
// encoded byte of the whole stream.
// A byte that only extends a run or joins the literal buffer sends no
// output. A byte that closes a run sends a packet, one byte per cycle
// unless the receiver stalls, paced by the output register. A final byte
// adds a flush step plus its own packet. The input is not ready while a
// packet is being sent; the literal buffer RAM reads one byte ahead.
// When the receiver stalls, the output register holds its byte and the
// controller waits; no byte is lost or repeated.
// Reset empties the pending run and the literal buffer and clears the
// output register; no clearing pass is needed.
module rle_literal_run_encoder #(
    parameter int LITERAL_LIMIT = 32,
    parameter int RUN_LIMIT     = 255
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] data_byte
    input  logic       i_s_axis_tlast,   // final_byte
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] code_byte
    output logic [0:0] o_m_axis_tuser,   // [0] group_last
    output logic       o_m_axis_tlast    // stream_done
);

    import rle_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;
    logic       group_last;

    // Sequencing of run decisions and packet bytes.
    rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .i_in_fin   (i_s_axis_tlast),
        .o_in_ready (o_s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Run state, literal buffer and output register.
    rle_dp #(
        .LITERAL_LIMIT (LITERAL_LIMIT),
        .RUN_LIMIT     (RUN_LIMIT)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_data         (i_s_axis_tdata),
        .i_in_fin          (i_s_axis_tlast),
        .i_out_ready       (i_m_axis_tready),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_out_valid       (o_m_axis_tvalid),
        .o_out_code        (o_m_axis_tdata),
        .o_out_group_last  (group_last),
        .o_out_stream_done (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = group_last;

endmodule

>>> rtl/rle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rle_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 32,
    parameter int ADDR_W = 5
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/rle_dp.sv
// Datapath: pending run, literal buffer, packet fields and the output register.
module rle_dp #(
    parameter int LITERAL_LIMIT = 32,
    parameter int RUN_LIMIT     = 255
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [7:0]           i_in_data,
    input  logic                 i_in_fin,
    input  logic                 i_out_ready,
    input  rle_pkg::t_dp_cmd     i_cmd,
    output rle_pkg::t_dp_status  o_status,
    output logic                 o_out_valid,
    output logic [7:0]           o_out_code,
    output logic                 o_out_group_last,
    output logic                 o_out_stream_done
);

    import rle_pkg::*;

    localparam int FILL_W = $clog2(LITERAL_LIMIT + 1);
    localparam int ADDR_W = (LITERAL_LIMIT > 1) ? $clog2(LITERAL_LIMIT) : 1;

    logic [FILL_W-1:0] r_fill;
    logic [FILL_W-1:0] r_idx;
    logic [7:0]        r_pv;
    logic [7:0]        r_pl;
    logic [7:0]        r_pkt_cnt;
    logic [7:0]        r_pkt_val;
    logic              r_fin;
    logic              r_ov;
    logic [7:0]        r_code;
    logic              r_last;
    logic              r_done;

    logic [FILL_W-1:0] idx_inc;
    logic [FILL_W-1:0] rd_idx;
    logic [7:0]        rd_data;
    logic [7:0]        emit_byte;

    assign idx_inc = r_idx + FILL_W'(1);
    assign rd_idx  = i_cmd.lit_adv ? idx_inc : r_idx;

    // Literal buffer: written at the fill index, read ahead at the send index.
    rle_ram #(
        .WIDTH  (8),
        .DEPTH  (LITERAL_LIMIT),
        .ADDR_W (ADDR_W)
    ) u_lit_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.append),
        .i_waddr (ADDR_W'(r_fill)),
        .i_wdata (r_pv),
        .i_raddr (ADDR_W'(rd_idx)),
        .o_rdata (rd_data)
    );

    // Status toward the controller.
    always_comb begin
        o_status.extend    = (r_pl != 8'd0) && (i_in_data == r_pv) && (r_pl < 8'(RUN_LIMIT));
        o_status.run_none  = (r_pl == 8'd0);
        o_status.run_multi = (r_pl > 8'd1);
        o_status.buf_full  = (r_fill >= FILL_W'(LITERAL_LIMIT));
        o_status.fill_zero = (r_fill == '0);
        o_status.lit_end   = (idx_inc == r_fill);
        o_status.fin       = r_fin;
        o_status.out_free  = !r_ov || i_out_ready;
    end

    // Byte chosen for the output register.
    always_comb begin
        case (i_cmd.emit_sel)
            SEL_CNT: emit_byte = 8'(r_fill);
            SEL_LIT: emit_byte = rd_data;
            SEL_RC:  emit_byte = r_pkt_cnt;
            SEL_RV:  emit_byte = r_pkt_val;
            default: emit_byte = r_pkt_val;
        endcase
    end

    // Pending run, literal fill and packet registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_pv   <= 8'd0;
            r_pl   <= 8'd0;
            r_fin  <= 1'b0;
        end else begin
            if (i_cmd.cap_in) begin
                r_fin <= i_in_fin;
            end
            if (i_cmd.run_ext) begin
                r_pl <= r_pl + 8'd1;
            end
            if (i_cmd.run_new) begin
                r_pv <= i_in_data;
                r_pl <= 8'd1;
            end
            if (i_cmd.run_clr) begin
                r_pv <= 8'd0;
                r_pl <= 8'd0;
            end
            if (i_cmd.append) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (i_cmd.fill_clr) begin
                r_fill <= '0;
            end
        end
    end

    // Packet run pair and literal send index; payload only.
    always_ff @(posedge i_clk) begin
        if (i_cmd.pkt_run) begin
            r_pkt_cnt <= r_pl;
            r_pkt_val <= r_pv;
            r_idx     <= '0;
        end else if (i_cmd.pkt_zero) begin
            r_pkt_cnt <= 8'd0;
            r_pkt_val <= 8'd0;
            r_idx     <= '0;
        end else if (i_cmd.lit_adv) begin
            r_idx <= idx_inc;
        end
    end

    // Output register: loaded on emit, emptied when the transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ov <= 1'b1;
        end else if (i_out_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_code <= emit_byte;
            r_last <= i_cmd.emit_last;
            r_done <= i_cmd.emit_done;
        end
    end

    assign o_out_valid       = r_ov;
    assign o_out_code        = r_code;
    assign o_out_group_last  = r_last;
    assign o_out_stream_done = r_done;

endmodule

>>> rtl/rle_ctrl.sv
// Controller: decides run/literal handling per byte and sequences packet bytes.
module rle_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_in_fin,
    output logic                 o_in_ready,
    input  rle_pkg::t_dp_status  i_status,
    output rle_pkg::t_dp_cmd     o_cmd
);

    import rle_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_fin_phase;
    logic   n_fin_phase;
    logic   item_end;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fin_phase <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fin_phase <= n_fin_phase;
        end
    end

    // The run value byte closes the item unless the stream-end packet still follows.
    assign item_end = r_fin_phase || !i_status.fin;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_fin_phase = r_fin_phase;
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.emit_sel = SEL_CNT;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.cap_in = 1'b1;
                    n_fin_phase  = 1'b0;
                    n_state      = i_in_fin ? ST_FIN : ST_IDLE;
                    if (i_status.extend) begin
                        o_cmd.run_ext = 1'b1;
                    end else if (i_status.run_none) begin
                        o_cmd.run_new = 1'b1;
                    end else if (i_status.run_multi || i_status.buf_full) begin
                        o_cmd.pkt_run = 1'b1;
                        o_cmd.run_new = 1'b1;
                        n_state       = ST_SEND_CNT;
                    end else begin
                        o_cmd.append  = 1'b1;
                        o_cmd.run_new = 1'b1;
                    end
                end
            end
            ST_FIN: begin
                // Stream end: resolve the pending run, then flush whatever is buffered.
                n_fin_phase   = 1'b1;
                o_cmd.run_clr = 1'b1;
                n_state       = ST_SEND_CNT;
                if (i_status.run_multi || i_status.buf_full) begin
                    o_cmd.pkt_run = 1'b1;
                end else begin
                    o_cmd.append   = 1'b1;
                    o_cmd.pkt_zero = 1'b1;
                end
            end
            ST_SEND_CNT: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_CNT;
                    n_state        = i_status.fill_zero ? ST_SEND_RC : ST_SEND_LIT;
                end
            end
            ST_SEND_LIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_LIT;
                    o_cmd.lit_adv  = 1'b1;
                    if (i_status.lit_end) begin
                        n_state = ST_SEND_RC;
                    end
                end
            end
            ST_SEND_RC: begin
                if (i_status.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.emit_sel = SEL_RC;
                    n_state        = ST_SEND_RV;
                end
            end
            ST_SEND_RV: begin
                if (i_status.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_sel  = SEL_RV;
                    o_cmd.emit_last = item_end;
                    o_cmd.emit_done = r_fin_phase;
                    o_cmd.fill_clr  = 1'b1;
                    n_state         = item_end ? ST_IDLE : ST_FIN;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule
